>>> hdl/hkm_pkg.sv
// ----------------------------------------------------------------------------
// hkm_pkg: shared types and constants
// Event codes, report kinds, control structs and saturation helpers for the
// keyboard/mouse report builder.
// ----------------------------------------------------------------------------
package hkm_pkg;

  localparam logic [9:0]  BTN_CODE_LO  = 10'h110;
  localparam logic [9:0]  BTN_CODE_HI  = 10'h114;
  localparam logic [7:0]  MOD_USAGE_LO = 8'hE0;
  localparam logic [7:0]  MOD_USAGE_HI = 8'hE7;
  localparam logic [14:0] COORD_MAX    = 15'd32767;
  localparam int          WHEEL_LIM    = 127;
  localparam int          REPORT_SLOTS = 6;

  typedef enum logic [1:0] {
    ACT_KEY      = 2'd0,
    ACT_MOTION   = 2'd1,
    ACT_POSITION = 2'd2,
    ACT_RESEND   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_KBD   = 2'd1,
    KIND_MOUSE = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // one captured input beat
  typedef struct packed {
    action_t            action;
    logic [9:0]         key_code;
    logic [7:0]         usage;
    logic               pressed;
    logic signed [16:0] x_arg;
    logic signed [16:0] y_arg;
    logic signed [15:0] wheel_arg;
    logic               sink_ready;
  } item_t;

  // key slot row control
  typedef struct packed {
    logic       ins;
    logic       rem;
    logic [7:0] usage;
  } key_op_t;

  // pointer unit control
  typedef struct packed {
    logic               btn_we;
    logic               btn_set;
    logic [2:0]         btn_idx;
    logic               motion;
    logic               position;
    logic signed [16:0] x_arg;
    logic signed [16:0] y_arg;
    logic signed [15:0] wheel_arg;
  } ptr_op_t;

  function automatic logic [14:0] clamp_coord(input logic signed [18:0] v);
    logic [14:0] r;
    if (v < 19'sd0) begin
      r = 15'd0;
    end else if (v > $signed({4'b0000, COORD_MAX})) begin
      r = COORD_MAX;
    end else begin
      r = v[14:0];
    end
    return r;
  endfunction

  // clamp to +/-127, then negate
  function automatic logic [7:0] wheel_from(input logic signed [15:0] z);
    logic signed [15:0] c;
    if (z < -16'(WHEEL_LIM)) begin
      c = -16'(WHEEL_LIM);
    end else if (z > 16'(WHEEL_LIM)) begin
      c = 16'(WHEEL_LIM);
    end else begin
      c = z;
    end
    return 8'(-c);
  endfunction

endpackage

>>> hdl/hkm_in_if.sv
// ----------------------------------------------------------------------------
// hkm_in_if: event input channel
// Valid/ready channel carrying one input event per beat.
// ----------------------------------------------------------------------------
interface hkm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [9:0]         key_code;
  logic [7:0]         usage;
  logic               pressed;
  logic signed [16:0] x_arg;
  logic signed [16:0] y_arg;
  logic signed [15:0] wheel_arg;
  logic               sink_ready;

  modport source (output valid, action, key_code, usage, pressed, x_arg, y_arg,
                  wheel_arg, sink_ready, input ready);
  modport sink (input valid, action, key_code, usage, pressed, x_arg, y_arg,
                wheel_arg, sink_ready, output ready);
endinterface

>>> hdl/hkm_out_if.sv
// ----------------------------------------------------------------------------
// hkm_out_if: result channel
// Valid/ready channel carrying the report state after each event.
// ----------------------------------------------------------------------------
interface hkm_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        report_kind;
  logic [7:0]        modifiers;
  logic [47:0]       key_slots;
  logic [4:0]        buttons;
  logic [14:0]       x_pos;
  logic [14:0]       y_pos;
  logic signed [7:0] wheel;
  logic              keyboard_pending;
  logic              mouse_pending;

  modport source (output valid, report_kind, modifiers, key_slots, buttons, x_pos,
                  y_pos, wheel, keyboard_pending, mouse_pending, input ready);
  modport sink (input valid, report_kind, modifiers, key_slots, buttons, x_pos,
                y_pos, wheel, keyboard_pending, mouse_pending, output ready);
endinterface

>>> hdl/hkm_cfg_if.sv
// ----------------------------------------------------------------------------
// hkm_cfg_if: configuration write channel
// Valid/ready channel carrying the enable register's write data.
// ----------------------------------------------------------------------------
interface hkm_cfg_if;
  logic valid;
  logic ready;
  logic enabled;

  modport source (output valid, enabled, input ready);
  modport sink (input valid, enabled, output ready);
endinterface

>>> hdl/hkm_key_cell.sv
// ----------------------------------------------------------------------------
// hkm_key_cell: one key slot
// Holds one usage byte; insert and release decisions ripple along the row.
// ----------------------------------------------------------------------------
module hkm_key_cell
  import hkm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  key_op_t    op,
  input  logic       done_in,   // insert already resolved to the left
  input  logic       found_in,  // released key found to the left
  input  logic       stop_in,   // empty slot seen to the left
  input  logic [7:0] next_val,  // right neighbor's byte
  output logic       done_out,
  output logic       found_out,
  output logic       stop_out,
  output logic [7:0] val
);

  logic [7:0] slot_r, slot_nxt;
  logic       match, empty, hit;

  assign match = (slot_r == op.usage);
  assign empty = (slot_r == 8'd0);
  assign hit   = !stop_in && !found_in && match;

  assign done_out  = done_in || match || empty;
  assign found_out = found_in || hit;
  assign stop_out  = stop_in || empty;
  assign val       = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (op.ins && !done_in && !match && empty) begin
      slot_nxt = op.usage;
    end else if (op.rem && (found_in || hit)) begin
      slot_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 8'd0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

endmodule

>>> hdl/hkm_key_row.sv
// ----------------------------------------------------------------------------
// hkm_key_row: row of key slot cells
// Chains the slot cells and packs the first six slots for the report.
// ----------------------------------------------------------------------------
module hkm_key_row
  import hkm_pkg::*;
#(
  parameter int KEY_SLOTS = 6
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  key_op_t     op,
  output logic [47:0] key_slots
);

  logic       done  [0:KEY_SLOTS];
  logic       found [0:KEY_SLOTS];
  logic       stop  [0:KEY_SLOTS];
  logic [7:0] val   [0:KEY_SLOTS];

  assign done[0]        = 1'b0;
  assign found[0]       = 1'b0;
  assign stop[0]        = 1'b0;
  assign val[KEY_SLOTS] = 8'd0;  // last slot refills with zero on a shift

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_cell
    hkm_key_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (op),
      .done_in  (done[i]),
      .found_in (found[i]),
      .stop_in  (stop[i]),
      .next_val (val[i+1]),
      .done_out (done[i+1]),
      .found_out(found[i+1]),
      .stop_out (stop[i+1]),
      .val      (val[i])
    );
  end

  for (genvar s = 0; s < REPORT_SLOTS; s++) begin : g_pack
    if (s < KEY_SLOTS) begin : g_used
      assign key_slots[8*s +: 8] = val[s];
    end else begin : g_zero
      assign key_slots[8*s +: 8] = 8'd0;
    end
  end

endmodule

>>> hdl/hkm_pointer.sv
// ----------------------------------------------------------------------------
// hkm_pointer: mouse report state
// Buttons, saturating X/Y and the wheel byte of the absolute mouse report.
// ----------------------------------------------------------------------------
module hkm_pointer
  import hkm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ptr_op_t           op,
  output logic [4:0]        buttons,
  output logic [14:0]       x_pos,
  output logic [14:0]       y_pos,
  output logic signed [7:0] wheel
);

  logic [4:0]  btn_r, btn_nxt;
  logic [14:0] x_r, x_nxt;
  logic [14:0] y_r, y_nxt;
  logic [7:0]  wheel_r, wheel_nxt;
  logic [4:0]  btn_bit;
  logic signed [18:0] x_sum, y_sum;

  assign btn_bit = 5'(5'd1 << op.btn_idx);
  assign x_sum   = $signed({4'b0000, x_r}) + 19'(op.x_arg);
  assign y_sum   = $signed({4'b0000, y_r}) + 19'(op.y_arg);

  always_comb begin
    btn_nxt   = btn_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    wheel_nxt = wheel_r;
    if (op.btn_we) begin
      btn_nxt = op.btn_set ? (btn_r | btn_bit) : (btn_r & ~btn_bit);
    end
    if (op.motion) begin
      x_nxt     = clamp_coord(x_sum);
      y_nxt     = clamp_coord(y_sum);
      wheel_nxt = wheel_from(op.wheel_arg);
    end else if (op.position) begin
      x_nxt     = clamp_coord(19'(op.x_arg));
      y_nxt     = clamp_coord(19'(op.y_arg));
      wheel_nxt = wheel_from(op.wheel_arg);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      btn_r   <= 5'd0;
      x_r     <= 15'd0;
      y_r     <= 15'd0;
      wheel_r <= 8'd0;
    end else begin
      btn_r   <= btn_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      wheel_r <= wheel_nxt;
    end
  end

  assign buttons = btn_r;
  assign x_pos   = x_r;
  assign y_pos   = y_r;
  assign wheel   = $signed(wheel_r);

endmodule

>>> hdl/hid_keyboard_mouse_report_builder.sv
// ----------------------------------------------------------------------------
// hid_keyboard_mouse_report_builder: keyboard and absolute mouse reports
// Applies key, button, motion, position and resend events to a 6KRO boot
// keyboard report and an absolute mouse report.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one event per beat (key, relative motion, absolute position or
//            resend). in_ch.ready is high only while the block is idle.
//   out_ch : one beat per event: report_kind (0 none, 1 keyboard, 2 mouse)
//            plus the full report state after the event.
//   cfg_ch : writes the enable bit; always ready. Write only while idle.
// Timing:
//   An event is latched at acceptance and applied in EXEC once the output
//   slot is free, when the state registers and the key slot row update and
//   the result beat becomes valid. The capture register holds one event, so
//   a new event is taken only after the last one is applied, back in IDLE.
// Stall:
//   While a result beat is waiting, the next event is still accepted and
//   captured; it is applied only once the waiting beat is taken.
// Reset:
//   rst_n (synchronous, active low) clears all slots, bits, coordinates,
//   pending flags and the enable bit; no result is valid.
// ----------------------------------------------------------------------------
module hid_keyboard_mouse_report_builder
  import hkm_pkg::*;
#(
  parameter int KEY_SLOTS = 6
)
(
  input  logic      clk,
  input  logic      rst_n,
  hkm_in_if.sink    in_ch,
  hkm_out_if.source out_ch,
  hkm_cfg_if.sink   cfg_ch
);

  state_t  state_r, state_nxt;
  item_t   item_r;
  logic    enabled_r;
  logic    out_valid_r, out_valid_nxt;
  kind_t   kind_r, kind_nxt;
  logic    kbd_pend_r, kbd_pend_nxt;
  logic    mouse_pend_r, mouse_pend_nxt;
  logic [7:0] mod_r, mod_nxt;

  logic    in_take, commit;
  logic    is_key, is_btn, is_kbd, is_mod, is_slot, is_ptr, is_resend;
  logic    deliver, kbd_offer, mouse_offer;
  logic [7:0] mod_bit;
  key_op_t key_op;
  ptr_op_t ptr_op;

  // --- control FSM: capture in IDLE, apply in EXEC ---
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_take = 1'b0;
    commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_take = 1'b1;
      ST_EXEC: commit  = !out_valid_r || out_ch.ready;  // output slot free
      default: ;
    endcase
  end

  assign in_ch.ready  = in_take;
  assign cfg_ch.ready = 1'b1;

  // --- event decode ---
  assign is_key    = (item_r.action == ACT_KEY);
  assign is_btn    = is_key && (item_r.key_code >= BTN_CODE_LO)
                     && (item_r.key_code <= BTN_CODE_HI);
  assign is_kbd    = is_key && !is_btn && (item_r.usage != 8'd0);
  assign is_mod    = is_kbd && (item_r.usage >= MOD_USAGE_LO)
                     && (item_r.usage <= MOD_USAGE_HI);
  assign is_slot   = is_kbd && !is_mod;
  assign is_ptr    = (item_r.action == ACT_MOTION) || (item_r.action == ACT_POSITION);
  assign is_resend = (item_r.action == ACT_RESEND);

  // report offer and delivery; resend prefers the keyboard report
  assign deliver     = enabled_r && item_r.sink_ready;
  assign kbd_offer   = is_kbd || (is_resend && kbd_pend_r);
  assign mouse_offer = is_btn || is_ptr || (is_resend && !kbd_pend_r && mouse_pend_r);

  assign mod_bit = 8'(8'd1 << item_r.usage[2:0]);

  always_comb begin
    kbd_pend_nxt   = kbd_pend_r;
    mouse_pend_nxt = mouse_pend_r;
    mod_nxt        = mod_r;
    kind_nxt       = kind_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    if (commit) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = KIND_NONE;
      if (kbd_offer) begin
        kbd_pend_nxt = !deliver;
        if (deliver) begin
          kind_nxt = KIND_KBD;
        end
      end else if (mouse_offer) begin
        mouse_pend_nxt = !deliver;
        if (deliver) begin
          kind_nxt = KIND_MOUSE;
        end
      end
      if (is_mod) begin
        mod_nxt = item_r.pressed ? (mod_r | mod_bit) : (mod_r & ~mod_bit);
      end
    end
  end

  // --- unit controls, qualified by commit ---
  always_comb begin
    key_op.ins   = commit && is_slot && item_r.pressed;
    key_op.rem   = commit && is_slot && !item_r.pressed;
    key_op.usage = item_r.usage;

    ptr_op.btn_we    = commit && is_btn;
    ptr_op.btn_set   = item_r.pressed;
    ptr_op.btn_idx   = item_r.key_code[2:0];
    ptr_op.motion    = commit && (item_r.action == ACT_MOTION);
    ptr_op.position  = commit && (item_r.action == ACT_POSITION);
    ptr_op.x_arg     = item_r.x_arg;
    ptr_op.y_arg     = item_r.y_arg;
    ptr_op.wheel_arg = item_r.wheel_arg;
  end

  // --- registers ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      enabled_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      kind_r       <= KIND_NONE;
      kbd_pend_r   <= 1'b0;
      mouse_pend_r <= 1'b0;
      mod_r        <= 8'd0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      kind_r       <= kind_nxt;
      kbd_pend_r   <= kbd_pend_nxt;
      mouse_pend_r <= mouse_pend_nxt;
      mod_r        <= mod_nxt;
      if (cfg_ch.valid) begin
        enabled_r <= cfg_ch.enabled;
      end
    end
  end

  // captured event payload
  always_ff @(posedge clk) begin
    if (in_take && in_ch.valid) begin
      item_r.action     <= action_t'(in_ch.action);
      item_r.key_code   <= in_ch.key_code;
      item_r.usage      <= in_ch.usage;
      item_r.pressed    <= in_ch.pressed;
      item_r.x_arg      <= in_ch.x_arg;
      item_r.y_arg      <= in_ch.y_arg;
      item_r.wheel_arg  <= in_ch.wheel_arg;
      item_r.sink_ready <= in_ch.sink_ready;
    end
  end

  // --- units ---
  hkm_key_row #(
    .KEY_SLOTS(KEY_SLOTS)
  ) u_key_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (key_op),
    .key_slots(out_ch.key_slots)
  );

  hkm_pointer u_pointer (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (ptr_op),
    .buttons(out_ch.buttons),
    .x_pos  (out_ch.x_pos),
    .y_pos  (out_ch.y_pos),
    .wheel  (out_ch.wheel)
  );

  // state only moves on commit, so it stays put while a beat waits
  assign out_ch.valid            = out_valid_r;
  assign out_ch.report_kind      = kind_r;
  assign out_ch.modifiers        = mod_r;
  assign out_ch.keyboard_pending = kbd_pend_r;
  assign out_ch.mouse_pending    = mouse_pend_r;

endmodule
